// ===== rtl/rlm_pkg.sv =====
// shared constants for the rms level meter
package rlm_pkg;

	localparam int BLOCK_MAX_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int MUL_W = 34;

	localparam logic [15:0] ATTACK_RESET  = 16'd42598;
	localparam logic [15:0] RELEASE_RESET = 16'd11796;
	localparam logic [6:0]  FLOOR_RESET   = 7'd60;

	localparam logic [18:0] LOG2_TO_DB = 19'd394566;
	localparam logic [14:0] DB_FLOOR   = 15'd24576;

	localparam logic [1:0] REG_ATTACK  = 2'd0;
	localparam logic [1:0] REG_RELEASE = 2'd1;
	localparam logic [1:0] REG_FLOOR   = 2'd2;

endpackage

// ===== rtl/rlm_mul.sv =====
// bit-serial shift-add multiplier
module rlm_mul #(
	parameter int W = rlm_pkg::MUL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic             done,
	output logic [2*W-1:0]   prod
);

	localparam int CW = $clog2(W + 1);

	logic [2*W-1:0] acc_q;
	logic [2*W-1:0] a_q;
	logic [W-1:0]   b_q;
	logic [CW-1:0]  cnt_q;
	logic           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q <= '0;
				a_q   <= {{W{1'b0}}, a};
				b_q   <= b;
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/rlm_div.sv =====
// bit-serial restoring divider
module rlm_div #(
	parameter int NW = 41,
	parameter int DW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   r2;
	logic          ge;

	assign r2 = {rem_q, quo_q[NW-1]};
	assign ge = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			d_q    <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= n;
				rem_q <= '0;
				d_q   <= d;
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				rem_q <= ge ? DW'(r2 - {1'b0, d_q}) : DW'(r2);
				quo_q <= {quo_q[NW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/block_rms_level_meter.sv =====
// rms level meter with dbfs conversion and attack/release smoothing
//
// Samples arrive on the src channel (src_valid/src_stall, sample, last); one
// transaction per sample. Each sample is squared by a bit-serial multiplier
// and added to the block sum if fewer than BLOCK_MAX samples are summed;
// src_stall stays high meanwhile, so the next sample waits for the square.
// A sample with last set also runs the end-of-block work: a serial divide
// of the sum by the count (one quotient bit per cycle), a square root at two
// bits per cycle, normalization, sixteen serial squarings for log2, a serial
// multiply to dB, a serial divide for the meter target and a serial multiply
// for the smoothing step.
// Results leave on the res channel (res_valid/res_stall) through an output
// register, so new samples are taken while a result waits; a stalled result
// only holds back the next end of block.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); the
// user must write it only while idle, which the block does not enforce. Reset
// restores the register defaults and clears the sum, the count and the meter.
module block_rms_level_meter #(
	parameter int BLOCK_MAX   = rlm_pkg::BLOCK_MAX_DEF,
	parameter int SAMPLE_BITS = rlm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic        [15:0]            rms_level,
	output logic signed [15:0]            level_dbfs,
	output logic        [15:0]            meter_level,
	input  logic                          cfg_wr_en,
	input  logic        [1:0]             cfg_index,
	input  logic        [15:0]            cfg_data
);

	localparam int MW     = rlm_pkg::MUL_W;
	localparam int SB     = SAMPLE_BITS;
	localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
	localparam int SUM_W  = 2 * SB - 2 + CNT_W;
	localparam int DIV_NW = (SUM_W > 32) ? SUM_W : 32;
	localparam int DIV_DW = (CNT_W > 15) ? CNT_W : 15;
	localparam int SH     = 34 - 2 * SB;
	localparam int SHL    = (SH > 0) ? SH : 0;
	localparam int SHR    = (SH < 0) ? -SH : 0;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SQ    = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_SQRT  = 4'd3;
	localparam logic [3:0] ST_NORM  = 4'd4;
	localparam logic [3:0] ST_LOG   = 4'd5;
	localparam logic [3:0] ST_DB    = 4'd6;
	localparam logic [3:0] ST_TPREP = 4'd7;
	localparam logic [3:0] ST_TGT   = 4'd8;
	localparam logic [3:0] ST_SPREP = 4'd9;
	localparam logic [3:0] ST_STEP  = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]        state_q;
	logic [15:0]       attack_q, release_q;
	logic [6:0]        floor_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_q;
	logic [15:0]       meter_q;

	logic              mul_go_q;
	logic [MW-1:0]     mul_a_q, mul_b_q;
	logic              mul_done;
	logic [2*MW-1:0]   mul_prod;
	logic              div_go_q;
	logic [DIV_NW-1:0] div_n_q;
	logic [DIV_DW-1:0] div_d_q;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;

	logic [33:0]       sq_val_q;
	logic [16:0]       root_q;
	logic [18:0]       rem_q;
	logic [4:0]        it_q;
	logic [15:0]       rms_q;
	logic [15:0]       norm_q;
	logic [3:0]        e_q;
	logic [15:0]       frac_q;
	logic [14:0]       dbm_q;
	logic [15:0]       target_q;
	logic              up_q;

	logic              res_valid_q;
	logic [15:0]       res_rms_q, res_db_q, res_meter_q;

	logic              src_acc;
	logic [SB-1:0]     raw, magn;
	logic              room;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [DIV_NW+SHL-1:0] q_ext;
	logic [33:0]       mean_s;
	logic [20:0]       rem2, trial;
	logic              sq_ge;
	logic [32:0]       yy;
	logic              lbit;
	logic [31:0]       y_new;
	logic [15:0]       frac_new;
	logic [20:0]       mag;
	logic [39:0]       dbp;
	logic [15:0]       dbr;
	logic [6:0]        fl;
	logic [14:0]       span;
	logic [15:0]       step;
	logic [15:0]       meter_new;
	logic              res_load;

	rlm_mul #(.W(MW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .prod(mul_prod)
	);

	rlm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q), .n(div_n_q), .d(div_d_q),
		.done(div_done), .quo(div_quo)
	);

	assign src_stall = (state_q != ST_IDLE);
	assign src_acc   = src_valid && !src_stall;
	assign raw       = sample;
	assign magn      = raw[SB-1] ? (~raw + 1'b1) : raw;

	assign room    = cnt_q < CNT_W'(BLOCK_MAX);
	assign sum_new = room ? sum_q + SUM_W'(mul_prod) : sum_q;
	assign cnt_new = room ? cnt_q + 1'b1 : cnt_q;

	assign q_ext  = (DIV_NW + SHL)'(div_quo) << SHL;
	assign mean_s = 34'(q_ext >> SHR);

	assign rem2  = {rem_q, sq_val_q[33:32]};
	assign trial = {2'b00, root_q, 2'b01};
	assign sq_ge = rem2 >= trial;

	assign yy       = mul_prod[63:31];
	assign lbit     = yy[32];
	assign y_new    = lbit ? yy[32:1] : yy[31:0];
	assign frac_new = {frac_q[14:0], lbit};
	assign mag      = 21'h100000 - {1'b0, e_q, frac_new};

	assign dbp = mul_prod[39:0] + 40'h800000;
	assign dbr = dbp[39:24];

	assign fl   = (floor_q == '0) ? 7'd1 : floor_q;
	assign span = {fl, 8'h00};

	assign step      = 16'((mul_prod[31:0] + 32'h8000) >> 16);
	assign meter_new = up_q ? meter_q + step : meter_q - step;

	assign res_load = (state_q == ST_OUT) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= rlm_pkg::ATTACK_RESET;
			release_q <= rlm_pkg::RELEASE_RESET;
			floor_q   <= rlm_pkg::FLOOR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rlm_pkg::REG_ATTACK:  attack_q  <= cfg_data;
				rlm_pkg::REG_RELEASE: release_q <= cfg_data;
				rlm_pkg::REG_FLOOR:   floor_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			meter_q     <= '0;
			mul_go_q    <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			div_go_q    <= 1'b0;
			div_n_q     <= '0;
			div_d_q     <= '0;
			sq_val_q    <= '0;
			root_q      <= '0;
			rem_q       <= '0;
			it_q        <= '0;
			rms_q       <= '0;
			norm_q      <= '0;
			e_q         <= '0;
			frac_q      <= '0;
			dbm_q       <= '0;
			target_q    <= '0;
			up_q        <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (src_acc) begin
						mul_a_q  <= MW'(magn);
						mul_b_q  <= MW'(magn);
						mul_go_q <= 1'b1;
						last_q   <= last;
						state_q  <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						sum_q <= sum_new;
						cnt_q <= cnt_new;
						if (last_q) begin
							div_n_q  <= DIV_NW'(sum_new);
							div_d_q  <= DIV_DW'(cnt_new);
							div_go_q <= 1'b1;
							state_q  <= ST_DIV;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						sq_val_q <= mean_s;
						root_q   <= '0;
						rem_q    <= '0;
						it_q     <= 5'd17;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (it_q != '0) begin
						rem_q    <= sq_ge ? 19'(rem2 - trial) : 19'(rem2);
						root_q   <= {root_q[15:0], sq_ge};
						sq_val_q <= sq_val_q << 2;
						it_q     <= it_q - 1'b1;
					end else begin
						rms_q  <= root_q[16] ? 16'hFFFF : root_q[15:0];
						norm_q <= root_q[16] ? 16'hFFFF : root_q[15:0];
						e_q    <= 4'd15;
						if (root_q == '0) begin
							dbm_q   <= rlm_pkg::DB_FLOOR;
							state_q <= ST_TPREP;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if (norm_q[15]) begin
						mul_a_q  <= MW'({norm_q, 16'h0000});
						mul_b_q  <= MW'({norm_q, 16'h0000});
						mul_go_q <= 1'b1;
						frac_q   <= '0;
						it_q     <= 5'd16;
						state_q  <= ST_LOG;
					end else begin
						norm_q <= norm_q << 1;
						e_q    <= e_q - 1'b1;
					end
				end
				ST_LOG: begin
					if (mul_done) begin
						frac_q   <= frac_new;
						it_q     <= it_q - 1'b1;
						mul_go_q <= 1'b1;
						if (it_q == 5'd1) begin
							mul_a_q <= MW'(mag);
							mul_b_q <= MW'(rlm_pkg::LOG2_TO_DB);
							state_q <= ST_DB;
						end else begin
							mul_a_q <= MW'(y_new);
							mul_b_q <= MW'(y_new);
						end
					end
				end
				ST_DB: begin
					if (mul_done) begin
						dbm_q   <= (dbr > 16'(rlm_pkg::DB_FLOOR)) ? rlm_pkg::DB_FLOOR
							: dbr[14:0];
						state_q <= ST_TPREP;
					end
				end
				ST_TPREP: begin
					if (dbm_q >= span) begin
						target_q <= '0;
						state_q  <= ST_SPREP;
					end else begin
						div_n_q  <= DIV_NW'({span - dbm_q, 16'h0000});
						div_d_q  <= DIV_DW'(span);
						div_go_q <= 1'b1;
						state_q  <= ST_TGT;
					end
				end
				ST_TGT: begin
					if (div_done) begin
						target_q <= (div_quo > DIV_NW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
						state_q  <= ST_SPREP;
					end
				end
				ST_SPREP: begin
					up_q     <= target_q > meter_q;
					mul_a_q  <= (target_q > meter_q) ? MW'(target_q - meter_q)
						: MW'(meter_q - target_q);
					mul_b_q  <= (target_q > meter_q) ? MW'(attack_q) : MW'(release_q);
					mul_go_q <= 1'b1;
					state_q  <= ST_STEP;
				end
				ST_STEP: begin
					if (mul_done) begin
						meter_q <= meter_new;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_load) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_rms_q   <= '0;
			res_db_q    <= '0;
			res_meter_q <= '0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
			res_rms_q   <= rms_q;
			res_db_q    <= 16'h0000 - {1'b0, dbm_q};
			res_meter_q <= meter_q;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid   = res_valid_q;
	assign rms_level   = res_rms_q;
	assign level_dbfs  = res_db_q;
	assign meter_level = res_meter_q;

endmodule

// ===== rtl/rlm_checker.sv =====
// port-level assertions for the rms level meter
module rlm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic        [15:0] rms_level,
	input logic signed [15:0] level_dbfs
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(level_dbfs) && $stable(rms_level))
		else $error("stalled result changed");

	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (level_dbfs <= 16'sd0) && (level_dbfs >= -16'sd24576))
		else $error("level out of range");

	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (rms_level == 16'd0) |-> (level_dbfs == -16'sd24576))
		else $error("silent block not at floor");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("sample taken without squaring time");

endmodule

bind block_rms_level_meter rlm_checker u_rlm_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for block_rms_level_meter with a bit-exact level predictor
module testbench;

	typedef struct {
		logic signed [15:0] smp;
		logic               lst;
	} sample_item_t;

	typedef struct {
		logic [15:0] rms;
		logic [15:0] db;
		logic [15:0] meter;
	} level_t;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int SETTLE      = 1000;

	localparam logic [1:0] REG_SPARE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	logic signed [15:0] sample = '0;
	logic               last = 1'b0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic        [15:0] rms_level;
	logic signed [15:0] level_dbfs;
	logic        [15:0] meter_level;
	logic               cfg_wr_en = 1'b0;
	logic        [1:0]  cfg_index = '0;
	logic        [15:0] cfg_data = '0;

	sample_item_t pending_samples[$];
	level_t       expected_levels[$];
	sample_item_t next_item;
	level_t       got_level;

	// predictor state and register mirror
	logic [15:0] attack_q = rlm_pkg::ATTACK_RESET;
	logic [15:0] release_q = rlm_pkg::RELEASE_RESET;
	logic [6:0]  floor_q = rlm_pkg::FLOOR_RESET;
	logic [63:0] sum_sq = '0;
	int unsigned n_acc = 0;
	logic [15:0] meter_q = '0;

	int src_idle_pct = 0;
	int res_stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int quiet_cycles = 0;

	block_rms_level_meter dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .sample(sample), .last(last),
		.res_valid(res_valid), .res_stall(res_stall),
		.rms_level(rms_level), .level_dbfs(level_dbfs), .meter_level(meter_level),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] b;
		rem = v;
		res = '0;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] db_below_full(input logic [15:0] r);
		int e;
		logic [63:0] y;
		logic [63:0] frac;
		logic [63:0] mag;
		e = 15;
		while (e > 0 && r[e] == 1'b0) e--;
		y = 64'(r) << (31 - e);
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				y = y >> 1;
				frac[0] = 1'b1;
			end
		end
		mag = (64'd16 << 16) - ((64'(e) << 16) + frac);
		mag = (mag * 64'(rlm_pkg::LOG2_TO_DB) + (64'd1 << 23)) >> 24;
		if (mag > 64'(rlm_pkg::DB_FLOOR)) mag = 64'(rlm_pkg::DB_FLOOR);
		return mag;
	endfunction

	task automatic accumulate_sample(input logic signed [15:0] smp, input logic lst);
		logic [63:0] magn;
		logic [63:0] mean;
		logic [63:0] rms;
		logic [63:0] dbm;
		logic [63:0] span;
		logic [63:0] target;
		logic [63:0] step;
		logic [63:0] fl;
		level_t lv;
		magn = smp[15] ? (64'd65536 - 64'(unsigned'(smp))) : 64'(unsigned'(smp));
		if (n_acc < rlm_pkg::BLOCK_MAX_DEF) begin
			sum_sq = sum_sq + magn * magn;
			n_acc++;
		end
		if (lst) begin
			mean = (sum_sq / 64'(n_acc)) << 2;
			rms = root_floor(mean);
			if (rms > 64'd65535) rms = 64'd65535;
			dbm = (rms == 0) ? 64'(rlm_pkg::DB_FLOOR) : db_below_full(rms[15:0]);
			fl = (floor_q == 0) ? 64'd1 : 64'(floor_q);
			span = fl * 256;
			if (dbm >= span) target = 0;
			else target = ((span - dbm) << 16) / span;
			if (target > 64'd65535) target = 64'd65535;
			if (target > 64'(meter_q)) begin
				step = ((target - 64'(meter_q)) * 64'(attack_q) + 64'd32768) >> 16;
				meter_q = meter_q + step[15:0];
			end else begin
				step = ((64'(meter_q) - target) * 64'(release_q) + 64'd32768) >> 16;
				meter_q = meter_q - step[15:0];
			end
			lv.rms = rms[15:0];
			lv.db = 16'(64'd0 - dbm);
			lv.meter = meter_q;
			expected_levels.push_back(lv);
			sum_sq = '0;
			n_acc = 0;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			sample <= '0;
			last <= 1'b0;
		end else if (!src_valid || !src_stall) begin
			if (src_valid) accumulate_sample(sample, last);
			if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				next_item = pending_samples.pop_front();
				sample <= next_item.smp;
				last <= next_item.lst;
				src_valid <= 1'b1;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_levels.size() == 0) begin
					$display("%0t unexpected transaction rms %h db %h meter %h", $time,
						rms_level, level_dbfs, meter_level);
					errors++;
				end else begin
					got_level = expected_levels.pop_front();
					if (rms_level !== got_level.rms) begin
						$display("%0t rms_level expected %h actual %h", $time,
							got_level.rms, rms_level);
						errors++;
					end
					if (level_dbfs !== got_level.db) begin
						$display("%0t level_dbfs expected %h actual %h", $time,
							got_level.db, level_dbfs);
						errors++;
					end
					if (meter_level !== got_level.meter) begin
						$display("%0t meter_level expected %h actual %h", $time,
							got_level.meter, meter_level);
						errors++;
					end
				end
			end
			res_stall <= (hold_left > 1) || (hold_seq != hold_seen) ||
				($urandom_range(99) < res_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("block_rms_level_meter: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			rlm_pkg::REG_ATTACK: attack_q = val;
			rlm_pkg::REG_RELEASE: release_q = val;
			rlm_pkg::REG_FLOOR: floor_q = val[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() > 0 || src_valid || expected_levels.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic push_sample(input logic signed [15:0] smp, input logic lst);
		sample_item_t it;
		it.smp = smp;
		it.lst = lst;
		pending_samples.push_back(it);
	endtask

	task automatic push_block(input int len, input int kind);
		logic signed [15:0] v;
		logic signed [15:0] c;
		int amp;
		amp = $urandom_range(15);
		c = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: v = 16'($urandom);
				1: v = 16'($signed($urandom_range(2 * (1 << amp))) - (1 << amp));
				2: v = c;
				3: v = '0;
				default: v = ($urandom_range(1)) ? 16'sh7fff : -16'sh8000;
			endcase
			push_sample(v, i == len - 1);
		end
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin src_idle_pct = 0; res_stall_pct = 0; end
			1: begin src_idle_pct = 60; res_stall_pct = 0; end
			2: begin src_idle_pct = 0; res_stall_pct = 60; end
			default: begin src_idle_pct = 20; res_stall_pct = 20; end
		endcase
	endtask

	initial begin
		int sent;
		int len;
		logic [15:0] a_set[8];
		logic [15:0] r_set[8];
		logic [15:0] f_set[8];
		a_set = '{16'hffff, 16'h0000, 16'd42598, 16'h0000, 16'hffff, 16'h8000, 16'h0001, 16'h1234};
		r_set = '{16'hffff, 16'h0000, 16'd11796, 16'hffff, 16'h0000, 16'h8000, 16'h0001, 16'h4321};
		f_set = '{16'd96, 16'd1, 16'd60, 16'd0, 16'hff7f, 16'd30, 16'd6, 16'd95};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: silence, full scale, tiny, mixed, then floor extremes
		push_sample(16'sd0, 1'b1);
		push_sample(-16'sh8000, 1'b1);
		push_sample(16'sh7fff, 1'b1);
		push_sample(16'sd1, 1'b1);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd1, 1'b1);
		push_sample(16'sh5555, 1'b0);
		push_sample(-16'sd21846, 1'b0);
		push_sample(16'sh7fff, 1'b0);
		push_sample(-16'sh8000, 1'b1);
		wait_drained();
		write_reg(rlm_pkg::REG_FLOOR, 16'd0);
		write_reg(REG_SPARE, 16'($urandom));
		push_sample(-16'sh8000, 1'b1);
		push_sample(16'sd300, 1'b1);
		wait_drained();
		write_reg(rlm_pkg::REG_FLOOR, 16'd96);
		write_reg(rlm_pkg::REG_ATTACK, 16'hffff);
		write_reg(rlm_pkg::REG_RELEASE, 16'hffff);
		push_sample(16'sd300, 1'b1);
		push_sample(16'sd0, 1'b1);
		push_sample(-16'sh8000, 1'b1);
		wait_drained();

		// overlong block
		push_block(1030, 0);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(rlm_pkg::REG_ATTACK, a_set[ph]);
			write_reg(rlm_pkg::REG_RELEASE, r_set[ph]);
			write_reg(rlm_pkg::REG_FLOOR, f_set[ph]);
			set_idling(ph % 4);
			sent = 0;
			while (sent < 70) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
				push_block(len, $urandom_range(4));
				sent += len;
			end
			wait_drained();
		end

		// receiver holds off while the sender keeps offering
		set_idling(0);
		hold_seq = hold_seq + 1;
		for (int i = 0; i < 30; i++) push_block($urandom_range(1, 2), $urandom_range(4));
		wait_drained();

		write_reg(rlm_pkg::REG_ATTACK, rlm_pkg::ATTACK_RESET);
		write_reg(rlm_pkg::REG_RELEASE, rlm_pkg::RELEASE_RESET);
		write_reg(rlm_pkg::REG_FLOOR, 16'(rlm_pkg::FLOOR_RESET));
		set_idling(3);
		for (int i = 0; i < 20; i++) push_block($urandom_range(1, 8), $urandom_range(4));
		wait_drained();

		if (errors == 0 && expected_levels.size() == 0) begin
			$display("block_rms_level_meter: match");
		end else begin
			$display("block_rms_level_meter: mismatch");
		end
		$finish;
	end

endmodule
